// File: hw/rtl/dnm_pkg.sv
// Package with shared types, constants and helpers for the NAT mapper.
package dnm_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW = 6;
  localparam int unsigned DivStages = 32;

  localparam logic [PortW-1:0] PortBase = 16'd1024;
  localparam logic [PortW-1:0] PortSpan = 16'd64512;

  localparam logic [CfgIdxW-1:0] RegEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInPrefix = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInLen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutPrefix = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPpu = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDisabled = 2'd1;
  localparam logic [1:0] StPrefix = 2'd2;
  localparam logic [1:0] StPort = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] address;
    logic [PortW-1:0] port;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] result_address;
    logic [PortW-1:0] block_start;
    logic [PortW-1:0] block_end;
  } rsp_t;

  // Work carried from cell to cell along the divider chain.
  typedef struct packed {
    logic             vld;
    logic             rev;
    logic [1:0]       status;
    logic [AddrW-1:0] rem;
    logic [AddrW-1:0] quo;
    logic [AddrW-1:0] div;
    logic [AddrW-1:0] acc;
    logic [PortW-1:0] ppu;
  } cell_t;

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    m = '1;
    if (len == '0) begin
      m = '0;
    end else if (len < LenW'(AddrW)) begin
      m = m << (LenW'(AddrW) - len);
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/dnm_cell.sv
// One restoring-division cell: produces one quotient bit per clock.
module dnm_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dnm_pkg::cell_t  in_i,
  output dnm_pkg::cell_t  out_o
);

  dnm_pkg::cell_t c_d, c_q;
  logic [dnm_pkg::AddrW:0] trial;
  logic [dnm_pkg::AddrW:0] sh;

  always_comb begin
    c_d = in_i;
    sh = {1'b0, in_i.rem >> Bit};
    trial = sh - {1'b0, in_i.div};
    if (in_i.div != '0 && !trial[dnm_pkg::AddrW]) begin
      c_d.quo[Bit] = 1'b1;
      c_d.rem = in_i.rem - (in_i.div << Bit);
    end else if (in_i.div == '0) begin
      c_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else begin
      c_q <= c_d;
    end
  end

  assign out_o = c_q;

endmodule

// File: hw/rtl/deterministic_nat_mapper.sv
// Top level of the deterministic NAT mapper with its divider cell chain.
// Requests enter on start with the request on req_i and are taken at an edge
// where busy is low. Each request yields exactly one response on rsp_o,
// flagged by done_o for one cycle. The entry register loads at the edge
// that takes the request, then DivStages division cells, one multiply
// register and one output register follow. Throughput is one request per
// clock while busy is low; the row of 32 division cells, one quotient bit
// each, sets the latency.
// Forward requests divide the host offset by subscribers per address;
// reverse requests divide the port offset by ports per user, and then
// multiply the address offset by subscribers per address.
// The user writes configuration through cfg_we_i, cfg_idx_i and cfg_data_i
// only while no request is in flight; the block does not enforce it. A
// write of ports per user raises busy while subscribers per address is
// recomputed one bit per cycle. Reset clears the valid flags and loads the
// default registers. The receiver cannot stall; done_o marks each response.
module deterministic_nat_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  dnm_pkg::req_t                  req_i,
  output logic                           done_o,
  output dnm_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_we_i,
  input  logic [dnm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dnm_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned AW = dnm_pkg::AddrW;
  localparam int unsigned PW = dnm_pkg::PortW;
  localparam int unsigned N = dnm_pkg::DivStages;

  logic          en_q;
  logic [AW-1:0] inp_q, outp_q;
  logic [dnm_pkg::LenW-1:0] len_q;
  logic [PW-1:0] ppu_q, spa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      inp_q <= 32'h6440_0000;
      len_q <= 6'd10;
      outp_q <= '0;
      ppu_q <= 16'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dnm_pkg::RegEnable: en_q <= cfg_data_i[0];
        dnm_pkg::RegInPrefix: inp_q <= cfg_data_i;
        dnm_pkg::RegInLen: len_q <= cfg_data_i[dnm_pkg::LenW-1:0];
        dnm_pkg::RegOutPrefix: outp_q <= cfg_data_i;
        dnm_pkg::RegPpu: ppu_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // Serial divider that derives subscribers per address from ports per user.
  logic [4:0]    sd_cnt_q;
  logic [PW-1:0] sd_rem_q, sd_quo_q, sd_rem_d, sd_quo_d;
  logic [PW:0]   sd_sh, sd_diff;

  always_comb begin
    sd_sh = {sd_rem_q, sd_quo_q[PW-1]};
    sd_diff = sd_sh - {1'b0, ppu_q};
    sd_quo_d = {sd_quo_q[PW-2:0], 1'b0};
    sd_rem_d = sd_sh[PW-1:0];
    if (sd_sh >= {1'b0, ppu_q}) begin
      sd_rem_d = sd_diff[PW-1:0];
      sd_quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_cnt_q <= '0;
      sd_rem_q <= '0;
      sd_quo_q <= '0;
      spa_q <= 16'd1008;
    end else if (cfg_we_i && cfg_idx_i == dnm_pkg::RegPpu) begin
      sd_cnt_q <= 5'd16;
      sd_rem_q <= '0;
      sd_quo_q <= dnm_pkg::PortSpan;
    end else if (sd_cnt_q != '0) begin
      sd_cnt_q <= sd_cnt_q - 5'd1;
      sd_rem_q <= sd_rem_d;
      sd_quo_q <= sd_quo_d;
      if (sd_cnt_q == 5'd1) begin
        spa_q <= sd_quo_d;
      end
    end
  end

  assign busy = (sd_cnt_q != '0);

  // Entry cell: checks and sets up the division.
  dnm_pkg::cell_t e_d, e_q;
  logic [AW-1:0] mask;

  always_comb begin
    mask = dnm_pkg::prefix_mask(len_q);
    e_d = '0;
    e_d.vld = start && !busy;
    e_d.rev = req_i.req_type;
    e_d.ppu = ppu_q;
    e_d.status = dnm_pkg::StOk;
    if (!en_q) begin
      e_d.status = dnm_pkg::StDisabled;
    end else if (!req_i.req_type) begin
      if ((req_i.address & mask) != (inp_q & mask)) begin
        e_d.status = dnm_pkg::StPrefix;
      end
      e_d.rem = req_i.address & ~mask;
      e_d.div = {{(AW-PW){1'b0}}, spa_q};
      e_d.acc = outp_q;
    end else begin
      if (req_i.port < dnm_pkg::PortBase) begin
        e_d.status = dnm_pkg::StPort;
      end
      e_d.rem = {{(AW-PW){1'b0}}, req_i.port - dnm_pkg::PortBase};
      e_d.div = {{(AW-PW){1'b0}}, ppu_q};
      e_d.acc = req_i.address - outp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
    end else begin
      e_q <= e_d;
    end
  end

  dnm_pkg::cell_t chain [N+1];
  assign chain[0] = e_q;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dnm_cell #(.Bit(N - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (chain[g]),
      .out_o (chain[g+1])
    );
  end

  // Multiply stage.
  dnm_pkg::cell_t t;
  logic          m_vld_q, m_rev_q;
  logic [1:0]    m_st_q;
  logic [AW-1:0] m_prod_q, m_quo_q, m_acc_q;
  logic [PW-1:0] m_ppu_q;

  assign t = chain[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= t.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_rev_q <= t.rev;
    m_st_q <= t.status;
    m_quo_q <= t.quo;
    m_acc_q <= t.acc;
    m_ppu_q <= t.ppu;
    if (t.rev) begin
      m_prod_q <= t.acc * {{(AW-PW){1'b0}}, spa_q};
    end else begin
      m_prod_q <= t.rem * {{(AW-PW){1'b0}}, t.ppu};
    end
  end

  // Output stage.
  dnm_pkg::rsp_t r_d, rsp_q;
  logic          done_q;
  logic [PW-1:0] bs;

  always_comb begin
    r_d = '0;
    r_d.status = m_st_q;
    bs = dnm_pkg::PortBase + m_prod_q[PW-1:0];
    if (m_st_q == dnm_pkg::StOk) begin
      if (m_rev_q) begin
        r_d.result_address = m_prod_q + m_quo_q + inp_q;
      end else begin
        r_d.result_address = m_acc_q + m_quo_q;
        r_d.block_start = bs;
        r_d.block_end = bs + m_ppu_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= r_d;
  end

  assign done_o = done_q;
  assign rsp_o = rsp_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q |=> done_o) else $error("response lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_vld_q |=> !done_o) else $error("spurious response");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != dnm_pkg::StOk) |-> (rsp_o.result_address == '0))
    else $error("error response carries data");

endmodule

// File: tb/deterministic_nat_mapper_tb.sv
// Self-checking testbench for the deterministic NAT mapper with random stimulus.
module deterministic_nat_mapper_tb;

  class nat_scoreboard;
    logic             en;
    logic [31:0]      in_pfx;
    logic [5:0]       in_len;
    logic [31:0]      out_pfx;
    logic [15:0]      ppu;
    logic [15:0]      subs;
    dnm_pkg::rsp_t    pending[$];
    int               errors;

    function void reset_regs();
      en = 1'b0;
      in_pfx = 32'h6440_0000;
      in_len = 6'd10;
      out_pfx = '0;
      ppu = 16'd64;
      subs = 16'd1008;
      errors = 0;
    endfunction

    function void write_reg(logic [dnm_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        dnm_pkg::RegEnable: en = val[0];
        dnm_pkg::RegInPrefix: in_pfx = val;
        dnm_pkg::RegInLen: in_len = val[5:0];
        dnm_pkg::RegOutPrefix: out_pfx = val;
        dnm_pkg::RegPpu: begin
          ppu = val[15:0];
          subs = (ppu == 0) ? 16'hFFFF : 16'(32'd64512 / ppu);
        end
        default: ;
      endcase
    endfunction

    function void note_request(dnm_pkg::req_t r);
      dnm_pkg::rsp_t e;
      logic [31:0]   mask, off, idx, slot, poff;
      e = '0;
      if (!en) begin
        e.status = dnm_pkg::StDisabled;
      end else if (!r.req_type) begin
        if (in_len == 0) mask = '0;
        else if (in_len >= 32) mask = '1;
        else mask = 32'hFFFF_FFFF << (32 - in_len);
        if ((r.address & mask) != (in_pfx & mask)) begin
          e.status = dnm_pkg::StPrefix;
        end else begin
          off = r.address & ~mask;
          if (subs == 0) begin
            idx = '1;
            slot = off;
          end else begin
            idx = off / subs;
            slot = off % subs;
          end
          e.status = dnm_pkg::StOk;
          e.result_address = out_pfx + idx;
          e.block_start = 16'(32'd1024 + slot * ppu);
          e.block_end = 16'(e.block_start + ppu - 16'd1);
        end
      end else if (r.port < dnm_pkg::PortBase) begin
        e.status = dnm_pkg::StPort;
      end else begin
        poff = 32'(r.port) - 32'd1024;
        slot = (ppu == 0) ? 32'hFFFF_FFFF : poff / ppu;
        e.status = dnm_pkg::StOk;
        e.result_address = (r.address - out_pfx) * subs + slot + in_pfx;
      end
      pending.push_back(e);
    endfunction

    function void check_response(dnm_pkg::rsp_t a);
      dnm_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status);
        errors++;
      end
      if (a.result_address !== e.result_address) begin
        $error("result_address exp %h got %h", e.result_address, a.result_address);
        errors++;
      end
      if (a.block_start !== e.block_start) begin
        $error("block_start exp %0d got %0d", e.block_start, a.block_start);
        errors++;
      end
      if (a.block_end !== e.block_end) begin
        $error("block_end exp %0d got %0d", e.block_end, a.block_end);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  dnm_pkg::req_t                req_i = '0;
  logic                         done_o;
  dnm_pkg::rsp_t                rsp_o;
  logic                         cfg_we_i = 1'b0;
  logic [dnm_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [dnm_pkg::CfgDataW-1:0] cfg_data_i = '0;
  nat_scoreboard                sb = new();
  int                           cycles = 0;

  deterministic_nat_mapper dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (done_o === 1'b1) sb.check_response(rsp_o);
    if (cycles > 400000) begin
      $display("deterministic_nat_mapper test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [dnm_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Holds start high until the request is taken; the caller lowers it.
  task automatic send(dnm_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(r);
  endtask

  task automatic send_dir(logic rt, logic [31:0] a, logic [15:0] p);
    dnm_pkg::req_t r;
    r.req_type = rt;
    r.address = a;
    r.port = p;
    send(r);
  endtask

  function automatic dnm_pkg::req_t rand_req();
    dnm_pkg::req_t r;
    logic [31:0] m;
    r.req_type = $urandom_range(0, 1);
    r.port = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
    if (sb.in_len == 0) m = '0;
    else if (sb.in_len >= 32) m = '1;
    else m = 32'hFFFF_FFFF << (32 - sb.in_len);
    if ($urandom_range(0, 9) < 8) begin
      r.address = r.req_type ? sb.out_pfx + $urandom_range(0, 300) : (sb.in_pfx & m) | ($urandom & ~m);
    end else begin
      r.address = $urandom;
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    int left, burst, gap, i;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      for (i = 0; i < burst; i++) send(rand_req());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_dir(1'b0, 32'h6440_0001, 16'd0);
    send_dir(1'b1, 32'h0, 16'd2000);
    drain();
    write_reg(dnm_pkg::RegEnable, 32'd1);
    send_dir(1'b0, 32'h6440_0000, 16'd0);
    send_dir(1'b0, 32'h647F_FFFF, 16'hFFFF);
    send_dir(1'b0, 32'hFFFF_FFFF, 16'd0);
    send_dir(1'b0, 32'h0, 16'd0);
    send_dir(1'b1, 32'h0, 16'd1023);
    send_dir(1'b1, 32'h0, 16'd1024);
    send_dir(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    drain();
    write_reg(dnm_pkg::RegInLen, 32'd0);
    write_reg(dnm_pkg::RegOutPrefix, 32'hFFFF_FFF0);
    write_reg(dnm_pkg::RegPpu, 32'd0);
    send_dir(1'b0, 32'hFFFF_FFFF, 16'd0);
    send_dir(1'b0, 32'h1234_5678, 16'd0);
    send_dir(1'b1, 32'h0, 16'hFFFF);
    drain();
    write_reg(dnm_pkg::RegInLen, 32'd63);
    write_reg(dnm_pkg::RegInPrefix, 32'hFFFF_FFFF);
    write_reg(dnm_pkg::RegPpu, 32'd65535);
    send_dir(1'b0, 32'hFFFF_FFFF, 16'd0);
    send_dir(1'b0, 32'hFFFF_FFFE, 16'd0);
    send_dir(1'b1, 32'h5, 16'd5000);
    drain();
    write_reg(dnm_pkg::RegInLen, 32'd32);
    write_reg(dnm_pkg::RegPpu, 32'd1);
    write_reg(dnm_pkg::RegInPrefix, 32'h0);
    send_dir(1'b0, 32'h0, 16'd0);
    send_dir(1'b1, 32'hFFFF_FFF0, 16'd1024);
    drain();
    write_reg(dnm_pkg::RegEnable, 32'd1);
    write_reg(dnm_pkg::RegInPrefix, 32'h0A00_0000);
    write_reg(dnm_pkg::RegInLen, 32'd8);
    write_reg(dnm_pkg::RegOutPrefix, 32'hC633_6400);
    write_reg(dnm_pkg::RegPpu, 32'd64512);
    random_phase(120);
    drain();
    for (int k = 0; k < 5; k++) begin
      write_reg(dnm_pkg::RegInPrefix, $urandom);
      write_reg(dnm_pkg::RegInLen, $urandom_range(0, 63));
      write_reg(dnm_pkg::RegOutPrefix, $urandom);
      write_reg(dnm_pkg::RegPpu, (k == 0) ? 32'd2000 : $urandom_range(1, 4096));
      write_reg(dnm_pkg::RegEnable, (k == 4) ? 32'd0 : 32'd1);
      random_phase(110);
      drain();
    end
    if (sb.errors == 0) begin
      $display("deterministic_nat_mapper test passed");
    end else begin
      $display("deterministic_nat_mapper test failed");
    end
    $finish;
  end

  final if (sb.pending.size() != 0) $error("responses missing: %0d", sb.pending.size());
endmodule

// File: filelist.f
hw/rtl/dnm_pkg.sv
hw/rtl/dnm_cell.sv
hw/rtl/deterministic_nat_mapper.sv
tb/deterministic_nat_mapper_tb.sv
